>>> src/mjd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mjd_pkg
// Shared types, constants and the header text table for the multipart
// stream deframer.
// ----------------------------------------------------------------------------
package mjd_pkg;

   localparam int unsigned LEN_W           = 21;
   localparam int unsigned MAX_FRAME_BYTES = 1048576;
   localparam int unsigned PROD_W          = LEN_W + 4;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic        CSR_IDX_MAX_LEN = 1'b0;

   localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(1000000);
   localparam logic [LEN_W-1:0] MAX_FRAME_LIM = LEN_W'(MAX_FRAME_BYTES);

   localparam logic [1:0] STATUS_DATA     = 2'd0;
   localparam logic [1:0] STATUS_TOO_LONG = 2'd1;
   localparam logic [1:0] STATUS_EMPTY    = 2'd2;

   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [3:0] HEADER_LEN = 4'd14;

   typedef enum logic [6:0] {
      PH_HUNT       = 7'b0000001,
      PH_TO_CR      = 7'b0000010,
      PH_HEADER     = 7'b0000100,
      PH_TO_SPACE   = 7'b0001000,
      PH_NUMBER     = 7'b0010000,
      PH_LINE_FEEDS = 7'b0100000,
      PH_DATA       = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] payload_byte;
      logic       last_byte;
      logic [1:0] status;
   } result_type;

   // "Content-Length", one character per index
   function automatic logic [7:0] header_char(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0:    c = 8'h43;
         4'd1:    c = 8'h6F;
         4'd2:    c = 8'h6E;
         4'd3:    c = 8'h74;
         4'd4:    c = 8'h65;
         4'd5:    c = 8'h6E;
         4'd6:    c = 8'h74;
         4'd7:    c = 8'h2D;
         4'd8:    c = 8'h4C;
         4'd9:    c = 8'h65;
         4'd10:   c = 8'h6E;
         4'd11:   c = 8'h67;
         4'd12:   c = 8'h74;
         4'd13:   c = 8'h68;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

>>> src/mjd_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mjd_ifs
// Valid/ready channels for stream bytes in and deframed results out.
// ----------------------------------------------------------------------------
interface mjd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink   (input valid, input stream_byte, output ready);
endinterface

interface mjd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       last_byte;
   logic [1:0] status;

   modport source (output valid, output payload_byte, output last_byte,
                   output status, input ready);
   modport sink   (input valid, input payload_byte, input last_byte,
                   input status, output ready);
endinterface
`default_nettype wire

>>> src/mjd_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mjd_csr
// APB register for the maximum frame length; keeps the clamped limit.
// ----------------------------------------------------------------------------
module mjd_csr
   import mjd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output logic      [LEN_W-1:0]      limit
);

   logic [LEN_W-1:0] max_len_ff, max_len_in;
   logic [LEN_W-1:0] limit_ff, limit_in;
   logic             wr_hit;

   assign wr_hit = psel && penable && pwrite && (paddr[2] == CSR_IDX_MAX_LEN);

   always_comb begin
      max_len_in = wr_hit ? pwdata[LEN_W-1:0] : max_len_ff;
      // limit in force is the smaller of the register and the build maximum
      limit_in   = (max_len_in > MAX_FRAME_LIM) ? MAX_FRAME_LIM : max_len_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
         limit_ff   <= MAX_LEN_RESET;
      end else begin
         max_len_ff <= max_len_in;
         limit_ff   <= limit_in;
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_IDX_MAX_LEN)
                 ? {{(CSR_DATA_W-LEN_W){1'b0}}, max_len_ff} : '0;
   assign limit  = limit_ff;

endmodule
`default_nettype wire

>>> src/mjd_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mjd_parser
// Parse state and per-byte next-state logic; yields at most one result.
// ----------------------------------------------------------------------------
module mjd_parser
   import mjd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire logic [7:0]       stream_byte,
   input  wire logic [LEN_W-1:0] limit,
   output result_type            result
);

   phase_type        phase_ff, phase_in;
   logic             dash_ff, dash_in;
   logic [3:0]       hidx_ff, hidx_in;
   logic             digits_ff, digits_in;
   logic [LEN_W-1:0] acc_ff, acc_in;
   logic             lf_ff, lf_in;
   logic [LEN_W-1:0] remain_ff, remain_in;

   logic [PROD_W-1:0] prod;
   logic [LEN_W-1:0]  limit_p1;
   logic [LEN_W-1:0]  remain_dec;
   logic [3:0]        hidx_next;
   logic [7:0]        b;

   assign b        = stream_byte;
   assign limit_p1 = limit + LEN_W'(1);
   assign prod     = (PROD_W'(acc_ff) << 3) + (PROD_W'(acc_ff) << 1)
                   + PROD_W'(b[3:0]);
   assign remain_dec = (remain_ff != '0) ? remain_ff - LEN_W'(1) : remain_ff;

   always_comb begin
      if ((hidx_ff < HEADER_LEN) && (b == header_char(hidx_ff)))
         hidx_next = hidx_ff + 4'd1;
      else
         hidx_next = (b == header_char(4'd0)) ? 4'd1 : 4'd0;
   end

   always_comb begin
      phase_in  = phase_ff;
      dash_in   = dash_ff;
      hidx_in   = hidx_ff;
      digits_in = digits_ff;
      acc_in    = acc_ff;
      lf_in     = lf_ff;
      remain_in = remain_ff;
      result    = '{valid: 1'b0, payload_byte: 8'h00, last_byte: 1'b0,
                    status: STATUS_DATA};
      case (phase_ff)
         PH_TO_CR: begin
            if (b == CHAR_CR) begin
               phase_in = PH_HEADER;
               hidx_in  = 4'd0;
            end
         end
         PH_HEADER: begin
            hidx_in = hidx_next;
            if (hidx_next >= HEADER_LEN)
               phase_in = PH_TO_SPACE;
         end
         PH_TO_SPACE: begin
            if (b == CHAR_SPACE) begin
               phase_in  = PH_NUMBER;
               digits_in = 1'b0;
               acc_in    = '0;
               lf_in     = 1'b0;
            end
         end
         PH_NUMBER: begin
            if (b inside {[CHAR_ZERO:CHAR_NINE]}) begin
               // saturate one past the limit so long strings stay flagged
               acc_in    = (prod > PROD_W'(limit)) ? limit_p1 : prod[LEN_W-1:0];
               digits_in = 1'b1;
            end else if ((b == CHAR_SPACE) && !digits_ff) begin
               phase_in = PH_NUMBER;
            end else if (acc_ff > limit) begin
               phase_in = PH_HUNT;
               dash_in  = 1'b0;
               result   = '{valid: 1'b1, payload_byte: 8'h00, last_byte: 1'b1,
                            status: STATUS_TOO_LONG};
            end else begin
               phase_in = PH_LINE_FEEDS;
               lf_in    = (b == CHAR_LF);
            end
         end
         PH_LINE_FEEDS: begin
            if (b == CHAR_LF) begin
               if (lf_ff) begin
                  if (acc_ff == '0) begin
                     phase_in = PH_HUNT;
                     dash_in  = 1'b0;
                     result   = '{valid: 1'b1, payload_byte: 8'h00,
                                  last_byte: 1'b1, status: STATUS_EMPTY};
                  end else begin
                     remain_in = acc_ff;
                     phase_in  = PH_DATA;
                  end
               end else begin
                  lf_in = 1'b1;
               end
            end
         end
         PH_DATA: begin
            remain_in = remain_dec;
            result    = '{valid: 1'b1, payload_byte: b,
                          last_byte: (remain_dec == '0), status: STATUS_DATA};
            if (remain_dec == '0) begin
               phase_in = PH_HUNT;
               dash_in  = 1'b0;
            end
         end
         default: begin
            if ((b == CHAR_DASH) && dash_ff) begin
               phase_in = PH_TO_CR;
               dash_in  = 1'b0;
            end else begin
               phase_in = PH_HUNT;
               dash_in  = (b == CHAR_DASH);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         dash_ff   <= 1'b0;
         hidx_ff   <= 4'd0;
         digits_ff <= 1'b0;
         acc_ff    <= '0;
         lf_ff     <= 1'b0;
         remain_ff <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         dash_ff   <= dash_in;
         hidx_ff   <= hidx_in;
         digits_ff <= digits_in;
         acc_ff    <= acc_in;
         lf_ff     <= lf_in;
         remain_ff <= remain_in;
      end
   end

endmodule
`default_nettype wire

>>> src/mjpeg_multipart_deframer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mjpeg_multipart_deframer
// Pulls JPEG payload bytes out of a multipart HTTP byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries raw stream bytes in; rsp_if carries results out, each a
//   payload byte with a last flag and a status code (data, length above the
//   limit, empty frame). Status results carry a zero byte and last set.
//   The APB port holds one register, max_frame_length, at byte address 0.
// Pipeline:
//   One item per cycle while rsp_if is not stalled. An accepted byte is
//   held in the input register, parsed against the current state when the
//   output register is free or draining, and its result (if any) is loaded
//   into the output register, which drives rsp_if.valid.
//   Rate is set by the single parse step between those two registers.
// Reset:
//   Synchronous, active high. Parser goes back to boundary hunting, both
//   registers empty, the limit returns to 1000000 bytes.
// Stall:
//   While a result waits on rsp_if, the parse step holds and the input
//   register keeps one byte; req_if.ready drops once both are full.
// ----------------------------------------------------------------------------
module mjpeg_multipart_deframer
   import mjd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   mjd_req_if.sink                    req_if,
   mjd_rsp_if.source                  rsp_if,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff, in_byte_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_byte_ff;
   logic             rsp_last_ff;
   logic [1:0]       rsp_status_ff;
   logic             advance;
   logic             req_fire;
   logic [LEN_W-1:0] limit;
   result_type       result;

   mjd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .limit   (limit)
   );

   mjd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .stream_byte (in_byte_ff),
      .limit       (limit),
      .result      (result)
   );

   // advance the held byte whenever the output register is free or draining
   assign advance  = in_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_fire = req_if.valid && req_if.ready;
   assign req_if.ready = !in_valid_ff || advance;

   always_comb begin
      in_byte_in  = req_fire ? req_if.stream_byte : in_byte_ff;
      if (req_fire)
         in_valid_in = 1'b1;
      else if (advance)
         in_valid_in = 1'b0;
      else
         in_valid_in = in_valid_ff;

      if (advance)
         rsp_valid_in = result.valid;
      else if (rsp_if.ready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers: load only, no reset
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      if (advance && result.valid) begin
         rsp_byte_ff   <= result.payload_byte;
         rsp_last_ff   <= result.last_byte;
         rsp_status_ff <= result.status;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.payload_byte = rsp_byte_ff;
   assign rsp_if.last_byte    = rsp_last_ff;
   assign rsp_if.status       = rsp_status_ff;

   // status results always close a frame
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != STATUS_DATA)) |-> rsp_last_ff)
      else $error("status result without last flag");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != STATUS_DATA)) |-> (rsp_byte_ff == 8'h00))
      else $error("status result with nonzero byte");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_status_ff == STATUS_DATA) ||
                        (rsp_status_ff == STATUS_TOO_LONG) ||
                        (rsp_status_ff == STATUS_EMPTY)))
      else $error("undefined status code");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid_ff && !rsp_if.ready) |-> !req_if.ready)
      else $error("input taken while both stages are blocked");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !in_valid_ff))
      else $error("stage valid after reset");

endmodule
`default_nettype wire
